// ===== hdl/btas_pkg.sv =====
// ============================================================================
// btas_pkg - block transfer address sequencer shared definitions
// Request and response payload types, mode codes and helper functions.
// ============================================================================
package btas_pkg;

    localparam int LIST_W  = 16;
    localparam int INDEX_W = 4;
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 5;

    localparam logic [1:0] MODE_IA = 2'd0;
    localparam logic [1:0] MODE_IB = 2'd1;
    localparam logic [1:0] MODE_DA = 2'd2;
    localparam logic [1:0] MODE_DB = 2'd3;

    localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic               is_load;
        logic               writeback;
        logic [INDEX_W-1:0] base_index;
        logic [LIST_W-1:0]  register_list;
        logic [ADDR_W-1:0]  base_address;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] register_index;
        logic [ADDR_W-1:0]  transfer_address;
        logic               no_transfer;
        logic               last;
        logic               base_write;
        logic [ADDR_W-1:0]  new_base;
    } rsp_t;

    // One operation of the shared address adder
    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
    } addr_op_t;

    function automatic logic [COUNT_W-1:0] list_count(input logic [LIST_W-1:0] list);
        logic [COUNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < LIST_W; i++)
        begin
            cnt = cnt + COUNT_W'(list[i]);
        end
        return cnt;
    endfunction

endpackage

// ===== hdl/btas_addr_unit.sv =====
// ============================================================================
// btas_addr_unit - shared address adder
// One 32-bit add/subtract used for the new base, the start address and
// every transfer address step. Sums wrap modulo 2^32.
// ============================================================================
module btas_addr_unit (
    input  btas_pkg::addr_op_t          op,
    output logic [btas_pkg::ADDR_W-1:0] sum
);
    import btas_pkg::*;

    always_comb
    begin
        if (op.sub)
        begin
            sum = op.a - op.b;
        end
        else
        begin
            sum = op.a + op.b;
        end
    end

endmodule

// ===== hdl/btas_bit_pick.sv =====
// ============================================================================
// btas_bit_pick - lowest set bit finder
// Returns the index and one-hot mask of the lowest set bit of the remaining
// register list.
// ============================================================================
module btas_bit_pick (
    input  logic [btas_pkg::LIST_W-1:0]  mask,
    output logic [btas_pkg::LIST_W-1:0]  onehot,
    output logic [btas_pkg::INDEX_W-1:0] index
);
    import btas_pkg::*;

    assign onehot = mask & (~mask + LIST_W'(1));

    always_comb
    begin
        index = '0;
        for (int i = 0; i < LIST_W; i++)
        begin
            index = index | (onehot[i] ? INDEX_W'(i) : '0);
        end
    end

endmodule

// ===== hdl/block_transfer_address_sequencer_core.sv =====
// ============================================================================
// block_transfer_address_sequencer_core - load/store multiple address sequencer
// Takes one block transfer request and issues one response per listed
// register in ascending order, the last one carrying the base writeback.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  btas_pkg::req_t
//   rsp       out        rsp_valid/rsp_stall  btas_pkg::rsp_t
//   cfg       in         cfg_we               cfg_data (arm9_rules)
//
// After acceptance the shared adder first computes the new base (S_SPAN),
// then the start address (S_START); S_EMIT then issues one response per
// cycle while rsp_stall does not hold the output, each stepping the address
// on the same adder. An empty list yields a single no-transfer response.
// req_stall is high from acceptance until the last response is loaded.
// rsp_stall holds the output register and pauses the sequencer.
// Reset is asynchronous; arm9_rules resets to 1.
// ============================================================================
module block_transfer_address_sequencer_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  btas_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output btas_pkg::rsp_t   rsp,
    input  logic             cfg_we,
    input  logic             cfg_data
);
    import btas_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SPAN  = 4'b0010,
        S_START = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg;
    logic [LIST_W-1:0]  list_reg, list_next;
    logic [COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  nb_reg, nb_next;
    logic               bw_reg, bw_next;
    logic               arm9_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    addr_op_t           op;
    logic [ADDR_W-1:0]  sum;
    logic [LIST_W-1:0]  pick_onehot;
    logic [INDEX_W-1:0] pick_index;
    logic               accept;
    logic               slot_free;
    logic               emit;
    logic               base_listed;
    logic               base_sole;
    logic               base_not_top;

    btas_addr_unit u_addr (
        .op  (op),
        .sum (sum)
    );

    btas_bit_pick u_pick (
        .mask   (list_reg),
        .onehot (pick_onehot),
        .index  (pick_index)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign emit      = (state_reg == S_EMIT) && slot_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign base_listed  = req_reg.register_list[req_reg.base_index];
    assign base_sole    = req_reg.register_list == (LIST_W'(1) << req_reg.base_index);
    assign base_not_top = (req_reg.register_list >> req_reg.base_index) != LIST_W'(1);

    // Shared adder operand select
    always_comb
    begin
        op = '{a: addr_reg, b: WORD_BYTES, sub: 1'b0};
        case (state_reg)
            S_SPAN:
            begin
                op.a   = req_reg.base_address;
                op.b   = ADDR_W'({count_reg, 2'b00});
                op.sub = req_reg.mode[1];
            end
            S_START:
            begin
                // decrement modes start from the lowered base
                op.a = req_reg.mode[1] ? nb_reg : req_reg.base_address;
                op.b = ((req_reg.mode == MODE_IB) || (req_reg.mode == MODE_DA)) ?
                       WORD_BYTES : '0;
            end
            default:
            begin
                op = '{a: addr_reg, b: WORD_BYTES, sub: 1'b0};
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        list_next      = list_reg;
        addr_next      = addr_reg;
        nb_next        = nb_reg;
        bw_next        = bw_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    list_next  = req.register_list;
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                nb_next = sum;
                bw_next = req_reg.writeback &&
                          (!req_reg.is_load || !base_listed ||
                           (arm9_reg && (base_sole || base_not_top)));
                state_next = S_START;
            end
            S_START:
            begin
                addr_next  = sum;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    rsp_valid_next = 1'b1;
                    if (list_reg == '0)
                    begin
                        rsp_next   = '{register_index: '0, transfer_address: '0,
                                       no_transfer: 1'b1, last: 1'b1,
                                       base_write: bw_reg, new_base: nb_reg};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        list_next = list_reg & ~pick_onehot;
                        addr_next = sum;
                        rsp_next.register_index   = pick_index;
                        rsp_next.transfer_address = addr_reg;
                        rsp_next.no_transfer      = 1'b0;
                        rsp_next.last             = (list_next == '0);
                        rsp_next.base_write       = (list_next == '0) && bw_reg;
                        rsp_next.new_base         = (list_next == '0) ? nb_reg : '0;
                        if (list_next == '0)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            arm9_reg      <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                arm9_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req;
            count_reg <= list_count(req.register_list);
        end
        list_reg <= list_next;
        addr_reg <= addr_next;
        nb_reg   <= nb_next;
        bw_reg   <= bw_next;
        rsp_reg  <= rsp_next;
    end

    // An empty-list response always closes the run
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.no_transfer |-> rsp.last)
        else $error("no-transfer response without last");

    // Writeback fields stay clear before the last response
    a_mid_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> !rsp.base_write && (rsp.new_base == '0))
        else $error("writeback fields set on a middle response");

    // An accepted request starts with the base computation
    a_accept_span: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SPAN))
        else $error("accepted request did not start the sequence");

    // The sequencer returns to idle only after issuing the last response
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && (state_next == S_IDLE) |=> rsp_valid && rsp.last)
        else $error("sequence ended without a last response");

endmodule

// ===== tb/transfer_monitor.sv =====
`timescale 1ns / 100ps
// ============================================================================
// transfer_monitor - scoreboard for the block transfer address sequencer
// Watches the request, response and configuration ports. Each accepted
// request is expanded into the transfers it should produce. Each accepted
// response is compared field by field with the oldest pending transfer.
// ============================================================================
module transfer_monitor (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  btas_pkg::req_t  req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  btas_pkg::rsp_t  rsp,
    input  logic            cfg_we,
    input  logic            cfg_data,
    output int              errors,
    output int              outstanding
);
    import btas_pkg::*;

    rsp_t pending_transfers[$];
    logic arm9_mode      = 1'b1;
    int   mismatch_count = 0;

    task automatic expand_request(input req_t r);
        logic [4:0]        count;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] next_base;
        logic              allowed;
        logic              base_wb;
        rsp_t              t;
        int                seen;
        count = '0;
        for (int i = 0; i < LIST_W; i++)
        begin
            count = count + {4'd0, r.register_list[i]};
        end
        span = {25'd0, count, 2'b00};
        case (r.mode)
            MODE_IA:
            begin
                addr      = r.base_address;
                next_base = r.base_address + span;
            end
            MODE_IB:
            begin
                addr      = r.base_address + WORD_BYTES;
                next_base = r.base_address + span;
            end
            MODE_DA:
            begin
                addr      = r.base_address - span + WORD_BYTES;
                next_base = r.base_address - span;
            end
            default:
            begin
                addr      = r.base_address - span;
                next_base = r.base_address - span;
            end
        endcase
        // a load that overwrites the base only writes it back under the v5 rule
        if (!r.is_load || !r.register_list[r.base_index])
            allowed = 1'b1;
        else if (arm9_mode)
            allowed = (r.register_list == (16'h0001 << r.base_index)) ||
                      ((r.register_list >> r.base_index) != 16'h0001);
        else
            allowed = 1'b0;
        base_wb = r.writeback & allowed;
        if (count == 0)
        begin
            t             = '0;
            t.no_transfer = 1'b1;
            t.last        = 1'b1;
            t.base_write  = base_wb;
            t.new_base    = r.base_address;
            pending_transfers.push_back(t);
        end
        else
        begin
            seen = 0;
            for (int i = 0; i < LIST_W; i++)
            begin
                if (r.register_list[i])
                begin
                    seen++;
                    t                  = '0;
                    t.register_index   = INDEX_W'(i);
                    t.transfer_address = addr;
                    if (seen == count)
                    begin
                        t.last       = 1'b1;
                        t.base_write = base_wb;
                        t.new_base   = next_base;
                    end
                    pending_transfers.push_back(t);
                    addr = addr + WORD_BYTES;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_transfer(input rsp_t got);
        rsp_t want;
        if (pending_transfers.size() == 0)
        begin
            $error("response with no request pending: register_index %0d address 0x%0h",
                   got.register_index, got.transfer_address);
            mismatch_count++;
        end
        else
        begin
            want = pending_transfers.pop_front();
            check_field("register_index", ADDR_W'(want.register_index),
                        ADDR_W'(got.register_index));
            check_field("transfer_address", want.transfer_address, got.transfer_address);
            check_field("no_transfer", ADDR_W'(want.no_transfer), ADDR_W'(got.no_transfer));
            check_field("last", ADDR_W'(want.last), ADDR_W'(got.last));
            check_field("base_write", ADDR_W'(want.base_write), ADDR_W'(got.base_write));
            check_field("new_base", want.new_base, got.new_base);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_transfers.delete();
            arm9_mode = 1'b1;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                arm9_mode = cfg_data;
            // retire the response before expanding a new request
            if (rsp_valid && !rsp_stall)
                compare_transfer(rsp);
            if (req_valid && !req_stall)
                expand_request(req);
            outstanding <= pending_transfers.size();
            errors      <= mismatch_count;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench - block transfer address sequencer verification top
// Drives directed corner requests and bursts of random requests under both
// base writeback rules, stalls the response side on random patterns and
// once for a long stretch, and reports the verdict from the scoreboard.
// ============================================================================
module testbench;
    import btas_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 24;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_data  = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;
    int   errors;
    int   outstanding;
    int   cycle_count  = 0;
    bit   hold_off_due = 1'b0;

    always #10 clk = ~clk;

    block_transfer_address_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    transfer_monitor scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Response side: random stall patterns, plus one long hold-off on demand
    initial
    begin
        int seg_left;
        int pattern;
        seg_left = 0;
        pattern  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_due)
            begin
                hold_off_due = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
                seg_left = 0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(4, 48);
                    pattern  = $urandom_range(0, 3);
                end
                seg_left--;
                case (pattern)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ~rsp_stall;
                    default: rsp_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    task automatic send_request(input req_t r);
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic send_fields(input logic [1:0] mode, input logic ld, input logic wb,
                               input logic [INDEX_W-1:0] bi,
                               input logic [LIST_W-1:0] list,
                               input logic [ADDR_W-1:0] base);
        req_t r;
        r.mode          = mode;
        r.is_load       = ld;
        r.writeback     = wb;
        r.base_index    = bi;
        r.register_list = list;
        r.base_address  = base;
        send_request(r);
    endtask

    // Drain: drop valid, wait for every pending transfer, then let the core settle
    task automatic drain_transfers();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_arm9_rules(input logic value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic req_t random_request();
        req_t        r;
        logic [15:0] bit_of_base;
        r.mode       = 2'($urandom_range(0, 3));
        r.is_load    = 1'($urandom_range(0, 1));
        r.writeback  = 1'($urandom_range(0, 1));
        r.base_index = 4'($urandom_range(0, 15));
        bit_of_base  = 16'h0001 << r.base_index;
        // lean on lists that contain the base, where the writeback rules differ
        case ($urandom_range(0, 9))
            0:       r.register_list = '0;
            1:       r.register_list = 16'hFFFF;
            2:       r.register_list = bit_of_base;
            3:       r.register_list = (16'($urandom) & (bit_of_base - 16'd1)) | bit_of_base;
            4:       r.register_list = 16'($urandom) | bit_of_base;
            5, 6:    r.register_list = 16'($urandom & $urandom & $urandom);
            default: r.register_list = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       r.base_address = 32'($urandom_range(0, 64));
            1:       r.base_address = 32'hFFFF_FFFF - 32'($urandom_range(0, 64));
            default: r.base_address = $urandom;
        endcase
        return r;
    endfunction

    task automatic run_random(input int count);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 8);
        for (int k = 0; k < count; k++)
        begin
            send_request(random_request());
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap        = $urandom_range(0, 10);
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Corner requests under the reset rule (v5 writeback)
        send_fields(MODE_IA, 1'b0, 1'b1, 4'd0,  16'h0000, 32'h0000_1000);
        send_fields(MODE_DB, 1'b1, 1'b0, 4'd15, 16'h0000, 32'hFFFF_FFFF);
        send_fields(MODE_IA, 1'b1, 1'b1, 4'd13, 16'hFFFF, 32'hFFFF_FFF0);
        send_fields(MODE_IB, 1'b0, 1'b1, 4'd15, 16'hFFFF, 32'hFFFF_FFFC);
        send_fields(MODE_DA, 1'b1, 1'b1, 4'd15, 16'hFFFF, 32'h0000_0000);
        send_fields(MODE_DB, 1'b0, 1'b1, 4'd0,  16'hFFFF, 32'h0000_003C);
        send_fields(MODE_IA, 1'b1, 1'b1, 4'd5,  16'h0020, 32'h0000_2000);
        send_fields(MODE_DB, 1'b1, 1'b1, 4'd7,  16'h00F0, 32'h1234_5678);
        send_fields(MODE_IB, 1'b1, 1'b1, 4'd3,  16'h000F, 32'h8000_0000);
        send_fields(MODE_DA, 1'b1, 1'b1, 4'd9,  16'h8001, 32'h0000_0008);
        send_fields(MODE_IA, 1'b0, 1'b1, 4'd2,  16'h0004, 32'hAAAA_5554);
        send_fields(MODE_DA, 1'b0, 1'b0, 4'd4,  16'h0001, 32'h0000_0002);
        send_fields(MODE_IB, 1'b1, 1'b0, 4'd0,  16'h8000, 32'h7FFF_FFFF);
        send_fields(MODE_DB, 1'b1, 1'b1, 4'd15, 16'h8000, 32'h5555_AAAB);
        drain_transfers();

        write_arm9_rules(1'b0);
        hold_off_due = 1'b1;
        run_random(55);
        drain_transfers();

        write_arm9_rules(1'b1);
        run_random(55);
        drain_transfers();

        write_arm9_rules(1'b0);
        run_random(50);
        drain_transfers();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/btas_pkg.sv
hdl/btas_addr_unit.sv
hdl/btas_bit_pick.sv
hdl/block_transfer_address_sequencer_core.sv
tb/transfer_monitor.sv
tb/testbench.sv
